// File: hw/rtl/sm3_pkg.sv
`timescale 1ns / 1ps

package sm3_pkg;

  typedef logic [31:0] word_t;

  // Eight 32-bit words; element 0 is register A (or chaining word 0).
  typedef logic [7:0][31:0] state8_t;

  localparam state8_t IV = {
    32'hB0FB0E4E, 32'hE38DEE4D, 32'h163138AA, 32'hA96F30BC,
    32'hDA8A0600, 32'h172442D7, 32'h4914B2B9, 32'h7380166F
  };

  localparam word_t T_LOW  = 32'h79CC4519;
  localparam word_t T_HIGH = 32'h7A879D8A;
  localparam word_t PAD_WORD = 32'h8000_0000;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam int unsigned ROUNDS = 64;
  localparam int unsigned BLOCK_WORDS = 16;

  typedef logic [$clog2(ROUNDS)-1:0] round_t;

  // Control of the message schedule window.
  typedef struct packed {
    logic  push;    // shift one message word into the window
    logic  expand;  // shift one expanded word into the window
    word_t data;    // message word for push
  } sched_ctl_t;

  // Control of the compression unit.
  typedef struct packed {
    logic   load;   // load A..H from the chaining value
    logic   step;   // run one round
    round_t round;  // round index j
  } comp_ctl_t;

  function automatic word_t rotl(input word_t x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic word_t perm0(input word_t x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic word_t perm1(input word_t x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

endpackage

// File: hw/rtl/sm3_msg_sched.sv
`timescale 1ns / 1ps

// Sixteen-word sliding window. Message words shift in at the top while a
// block is collected; during compression each round shifts in W[j+16], so
// the bottom always holds W[j] and W[j+4].
module sm3_msg_sched (
  input  logic                clk,
  input  sm3_pkg::sched_ctl_t ctl,
  output sm3_pkg::word_t      w_j,
  output sm3_pkg::word_t      wp_j
);

  sm3_pkg::word_t win_r [sm3_pkg::BLOCK_WORDS];
  sm3_pkg::word_t expd;

  always_comb begin
    expd = sm3_pkg::perm1(win_r[0] ^ win_r[7] ^ sm3_pkg::rotl(win_r[13], 5'd15))
         ^ sm3_pkg::rotl(win_r[3], 5'd7) ^ win_r[10];
  end

  always_ff @(posedge clk) begin
    if (ctl.push || ctl.expand) begin
      for (int i = 0; i < sm3_pkg::BLOCK_WORDS - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[sm3_pkg::BLOCK_WORDS-1] <= ctl.push ? ctl.data : expd;
    end
  end

  assign w_j  = win_r[0];
  assign wp_j = win_r[0] ^ win_r[4];

endmodule

// File: hw/rtl/sm3_compress.sv
`timescale 1ns / 1ps

// Working registers A..H and the round function, one round per step.
module sm3_compress (
  input  logic                 clk,
  input  sm3_pkg::comp_ctl_t   ctl,
  input  sm3_pkg::state8_t     cv,
  input  sm3_pkg::word_t       w_j,
  input  sm3_pkg::word_t       wp_j,
  output sm3_pkg::state8_t     regs
);

  sm3_pkg::state8_t r_r;
  sm3_pkg::state8_t r_nxt;

  always_comb begin
    sm3_pkg::word_t a12, tj, ss1, ss2, ff, gg, tt1, tt2;
    logic early;
    early = (ctl.round < sm3_pkg::round_t'(16));
    a12 = sm3_pkg::rotl(r_r[0], 5'd12);
    tj  = early ? sm3_pkg::T_LOW : sm3_pkg::T_HIGH;
    ss1 = sm3_pkg::rotl(a12 + r_r[4] + sm3_pkg::rotl(tj, ctl.round[4:0]), 5'd7);
    ss2 = ss1 ^ a12;
    if (early) begin
      ff = r_r[0] ^ r_r[1] ^ r_r[2];
      gg = r_r[4] ^ r_r[5] ^ r_r[6];
    end else begin
      ff = (r_r[0] & r_r[1]) | (r_r[0] & r_r[2]) | (r_r[1] & r_r[2]);
      gg = (r_r[4] & r_r[5]) | (~r_r[4] & r_r[6]);
    end
    tt1 = ff + r_r[3] + ss2 + wp_j;
    tt2 = gg + r_r[7] + ss1 + w_j;
    r_nxt[3] = r_r[2];
    r_nxt[2] = sm3_pkg::rotl(r_r[1], 5'd9);
    r_nxt[1] = r_r[0];
    r_nxt[0] = tt1;
    r_nxt[7] = r_r[6];
    r_nxt[6] = sm3_pkg::rotl(r_r[5], 5'd19);
    r_nxt[5] = r_r[4];
    r_nxt[4] = sm3_pkg::perm0(tt2);
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      r_r <= cv;
    end else if (ctl.step) begin
      r_r <= r_nxt;
    end
  end

  assign regs = r_r;

endmodule

// File: hw/rtl/sm3_hash_engine_core.sv
`timescale 1ns / 1ps
// The engine takes no new word while a block is compressed: the sixteenth word
// of a block is pushed, then 64 rounds and one fold run before in_tready rises.
// After a final word, padding pushes and one or two compressions come before
// the first digest transfer.
// Reset (rst_n low, synchronous): chaining value to the SM3 IV, length and
// word position to zero, sequencer idle, no output pending.

// SM3 hash engine. Message words enter one per transfer; sixteen of them
// form a block. A full block is compressed by one shared round unit that
// runs 64 times under a small sequencer while the message schedule window
// produces W[j] and W'[j] on the fly. The compression unit holds A..H; the
// chaining value lives here and is folded with A..H after the last round.
//
// A final word (in_tlast) is masked to its valid bytes and gets the 0x80
// pad byte. The sequencer then pushes the remaining pad words one per cycle,
// except during a compression: a lone 0x80000000 word when the final word was
// full, zeros up to word fourteen (through an extra block if needed), then the
// 64-bit bit length. After the last compression the eight digest words leave
// as transfers on the output channel; the engine returns to the initial value.
module sm3_hash_engine_core (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // message_word [31:0]
  input  logic [2:0]  in_tuser,   // byte_count [2:0]
  input  logic        in_tlast,   // last_word
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // digest_word [31:0]
  output logic        out_tlast   // digest_last
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROUND,
    S_FOLD,
    S_PAD,
    S_OUT
  } state_t;

  state_t               state_r, state_nxt;
  logic [3:0]           pos_r, pos_nxt;
  logic [60:0]          bytes_r, bytes_nxt;
  sm3_pkg::state8_t     cv_r, cv_nxt;
  sm3_pkg::round_t      round_r, round_nxt;
  logic [2:0]           oidx_r, oidx_nxt;
  logic                 pend_r, pend_nxt;   // 0x80000000 word still owed
  logic                 pad_r, pad_nxt;     // padding of a final word under way
  logic                 hi_r, hi_nxt;       // upper length word pushed
  logic                 done_r, done_nxt;   // lower length word pushed

  sm3_pkg::sched_ctl_t  sched_ctl;
  sm3_pkg::comp_ctl_t   comp_ctl;
  sm3_pkg::word_t       w_j, wp_j;
  sm3_pkg::state8_t     regs;

  logic                 in_xfer;
  logic                 out_xfer;
  logic [2:0]           cnt_sat;
  sm3_pkg::word_t       last_fmt;
  sm3_pkg::word_t       pad_data;
  logic [63:0]          bit_len;
  logic                 full;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = cv_r[oidx_r];
  assign out_tlast  = (oidx_r == 3'd7);

  assign in_xfer  = in_tvalid && in_tready;
  assign out_xfer = out_tvalid && out_tready;
  assign bit_len  = {bytes_r, 3'b000};

  // The final word keeps only its valid leading bytes; the pad byte follows.
  always_comb begin
    cnt_sat = (in_tuser > 3'd4) ? 3'd4 : in_tuser;
    case (cnt_sat)
      3'd0:    last_fmt = {sm3_pkg::PAD_BYTE, 24'h0};
      3'd1:    last_fmt = {in_tdata[31:24], sm3_pkg::PAD_BYTE, 16'h0};
      3'd2:    last_fmt = {in_tdata[31:16], sm3_pkg::PAD_BYTE, 8'h0};
      3'd3:    last_fmt = {in_tdata[31:8], sm3_pkg::PAD_BYTE};
      default: last_fmt = in_tdata;
    endcase
  end

  // Pad word for the current position once the final word is in.
  always_comb begin
    if (pend_r) begin
      pad_data = sm3_pkg::PAD_WORD;
    end else if (pos_r == 4'd14) begin
      pad_data = bit_len[63:32];
    end else if (pos_r == 4'd15 && hi_r) begin
      pad_data = bit_len[31:0];
    end else begin
      pad_data = '0;
    end
  end

  always_comb begin
    sched_ctl.push   = in_xfer || (state_r == S_PAD);
    sched_ctl.expand = (state_r == S_ROUND);
    sched_ctl.data   = (state_r == S_PAD) ? pad_data
                     : (in_tlast ? last_fmt : in_tdata);
  end

  assign full = sched_ctl.push && (pos_r == 4'd15);

  always_comb begin
    comp_ctl.load  = full;
    comp_ctl.step  = (state_r == S_ROUND);
    comp_ctl.round = round_r;
  end

  sm3_msg_sched u_sched (
    .clk  (clk),
    .ctl  (sched_ctl),
    .w_j  (w_j),
    .wp_j (wp_j)
  );

  sm3_compress u_comp (
    .clk  (clk),
    .ctl  (comp_ctl),
    .cv   (cv_r),
    .w_j  (w_j),
    .wp_j (wp_j),
    .regs (regs)
  );

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = sched_ctl.push ? pos_r + 4'd1 : pos_r;
    bytes_nxt = bytes_r;
    cv_nxt    = cv_r;
    round_nxt = round_r;
    oidx_nxt  = oidx_r;
    pend_nxt  = pend_r;
    pad_nxt   = pad_r;
    hi_nxt    = hi_r;
    done_nxt  = done_r;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_tlast) begin
            bytes_nxt = bytes_r + 61'(cnt_sat);
            pend_nxt  = (cnt_sat == 3'd4);
            pad_nxt   = 1'b1;
            state_nxt = full ? S_ROUND : S_PAD;
          end else begin
            bytes_nxt = bytes_r + 61'd4;
            state_nxt = full ? S_ROUND : S_IDLE;
          end
          round_nxt = '0;
        end
      end
      S_PAD: begin
        if (pend_r) begin
          pend_nxt = 1'b0;
        end else if (pos_r == 4'd14) begin
          hi_nxt = 1'b1;
        end else if (pos_r == 4'd15 && hi_r) begin
          done_nxt = 1'b1;
        end
        round_nxt = '0;
        if (full) begin
          state_nxt = S_ROUND;
        end
      end
      S_ROUND: begin
        round_nxt = round_r + sm3_pkg::round_t'(1);
        if (round_r == sm3_pkg::round_t'(sm3_pkg::ROUNDS - 1)) begin
          state_nxt = S_FOLD;
        end
      end
      S_FOLD: begin
        cv_nxt = cv_r ^ regs;
        if (done_r) begin
          oidx_nxt  = '0;
          state_nxt = S_OUT;
        end else if (pad_r) begin
          state_nxt = S_PAD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_OUT: begin
        if (out_xfer) begin
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == 3'd7) begin
            cv_nxt    = sm3_pkg::IV;
            bytes_nxt = '0;
            pos_nxt   = '0;
            pad_nxt   = 1'b0;
            hi_nxt    = 1'b0;
            done_nxt  = 1'b0;
            pend_nxt  = 1'b0;
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pos_r   <= '0;
      bytes_r <= '0;
      cv_r    <= sm3_pkg::IV;
      round_r <= '0;
      oidx_r  <= '0;
      pend_r  <= 1'b0;
      pad_r   <= 1'b0;
      hi_r    <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      bytes_r <= bytes_nxt;
      cv_r    <= cv_nxt;
      round_r <= round_nxt;
      oidx_r  <= oidx_nxt;
      pend_r  <= pend_nxt;
      pad_r   <= pad_nxt;
      hi_r    <= hi_nxt;
      done_r  <= done_nxt;
    end
  end

endmodule

// File: dv/tb_sm3_hash_engine_core.sv
`timescale 1ns / 1ps

// Self-checking bench for the SM3 engine. Whole messages are queued as
// transfers of one 32-bit word each, and a clocked driver presents them with
// random gaps. A scoreboard model of SM3 runs alongside. Every accepted word
// is absorbed there, and a final word yields the eight digest words that the
// result channel must deliver in order. The result side stalls at random too.
module tb_sm3_hash_engine_core;

  // This bound only catches a hung engine.
  localparam int unsigned CYCLE_LIMIT = 800000;
  localparam int unsigned WORD_TARGET = 410;

  // One input transfer: message word, valid byte count, end of message.
  typedef struct {
    sm3_pkg::word_t word;
    logic [2:0]     cnt;
    logic           fin;
  } msg_item_t;

  // One digest word as the result channel should carry it.
  typedef struct {
    sm3_pkg::word_t word;
    logic           last;
  } digest_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tlast;

  sm3_hash_engine_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Words waiting to be driven, and digest words still owed by the engine.
  msg_item_t word_q[$];
  digest_t   digest_q[$];

  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  int unsigned words_queued = 0;

  // Scoreboard copy of the hash state: chaining value, partial block,
  // word position within the block and the byte length of the message.
  sm3_pkg::word_t chain_v[8];
  sm3_pkg::word_t blk_w[16];
  int unsigned    fill_pos;
  logic [60:0]    byte_len;

  // Handshake flags from the last rising edge, read by the drivers at the
  // falling edge.
  logic in_done = 1'b0;
  logic out_done = 1'b0;

  // Driver bookkeeping. A calm flag switches a side to back-to-back
  // operation for a while, so that stretches without idling occur as well.
  int unsigned in_gap = 0;
  int unsigned out_hold = 0;
  logic        in_calm = 1'b0;
  logic        out_calm = 1'b0;
  logic        nxt_valid;
  logic        nxt_ready;
  msg_item_t   cur_item;
  digest_t     want;

  // ---------------------------------------------------------------------
  // SM3 scoreboard model
  // ---------------------------------------------------------------------

  // Rotate left; the amount is reduced mod 32, which matters for T rotated
  // by round indexes of 32 and up.
  function automatic sm3_pkg::word_t rol(input sm3_pkg::word_t x, input int unsigned n);
    int unsigned s;
    s = n % 32;
    if (s == 0) return x;
    return (x << s) | (x >> (32 - s));
  endfunction

  function automatic sm3_pkg::word_t mix0(input sm3_pkg::word_t x);
    return x ^ rol(x, 9) ^ rol(x, 17);
  endfunction

  function automatic sm3_pkg::word_t mix1(input sm3_pkg::word_t x);
    return x ^ rol(x, 15) ^ rol(x, 23);
  endfunction

  // Expand the held block and run all 64 rounds, then fold into the
  // chaining value. W'[j] is formed on the fly as W[j] ^ W[j+4].
  function automatic void fold_block();
    sm3_pkg::word_t w[68];
    sm3_pkg::word_t a, b, c, d, e, f, g, h;
    sm3_pkg::word_t a12, ss1, ss2, tt1, tt2, tj, ff, gg;
    int j;
    for (j = 0; j < 16; j++) w[j] = blk_w[j];
    for (j = 16; j < 68; j++)
      w[j] = mix1(w[j-16] ^ w[j-9] ^ rol(w[j-3], 15)) ^ rol(w[j-13], 7) ^ w[j-6];
    a = chain_v[0]; b = chain_v[1]; c = chain_v[2]; d = chain_v[3];
    e = chain_v[4]; f = chain_v[5]; g = chain_v[6]; h = chain_v[7];
    for (j = 0; j < 64; j++) begin
      tj  = (j < 16) ? sm3_pkg::T_LOW : sm3_pkg::T_HIGH;
      a12 = rol(a, 12);
      ss1 = rol(a12 + e + rol(tj, j), 7);
      ss2 = ss1 ^ a12;
      if (j < 16) begin
        ff = a ^ b ^ c;
        gg = e ^ f ^ g;
      end else begin
        ff = (a & b) | (a & c) | (b & c);
        gg = (e & f) | (~e & g);
      end
      tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
      tt2 = gg + h + ss1 + w[j];
      d = c; c = rol(b, 9); b = a; a = tt1;
      h = g; g = rol(f, 19); f = e; e = mix0(tt2);
    end
    chain_v[0] ^= a; chain_v[1] ^= b; chain_v[2] ^= c; chain_v[3] ^= d;
    chain_v[4] ^= e; chain_v[5] ^= f; chain_v[6] ^= g; chain_v[7] ^= h;
  endfunction

  function automatic void append_word(input sm3_pkg::word_t w);
    blk_w[fill_pos] = w;
    fill_pos++;
    if (fill_pos == sm3_pkg::BLOCK_WORDS) begin
      fold_block();
      fill_pos = 0;
    end
  endfunction

  function automatic void restart_hash();
    int k;
    for (k = 0; k < 8; k++) chain_v[k] = sm3_pkg::IV[k];
    fill_pos = 0;
    byte_len = '0;
  endfunction

  // Absorb one accepted word. A non-final word always counts four bytes.
  // A final word is cut to its valid bytes (counts above four act as four),
  // padded, closed with the bit length and turned into eight digest words.
  function automatic void absorb_word(input sm3_pkg::word_t data, input logic [2:0] cnt,
                                      input logic fin);
    int nb;
    sm3_pkg::word_t keep;
    logic [63:0] bits;
    digest_t dw;
    int k;
    if (!fin) begin
      byte_len += 61'd4;
      append_word(data);
      return;
    end
    nb = (cnt > 3'd4) ? 4 : int'(cnt);
    byte_len += 61'(nb);
    if (nb == 4) begin
      append_word(data);
      append_word(sm3_pkg::PAD_WORD);
    end else begin
      keep = (nb == 0) ? '0 : (32'hFFFF_FFFF << (32 - 8 * nb));
      append_word((data & keep) | (sm3_pkg::word_t'(sm3_pkg::PAD_BYTE) << (24 - 8 * nb)));
    end
    // No room for the length in this block: close it with zeros first.
    if (fill_pos > 14) begin
      while (fill_pos != 0) append_word('0);
    end
    while (fill_pos < 14) append_word('0);
    bits = {byte_len, 3'b000};
    append_word(bits[63:32]);
    append_word(bits[31:0]);
    for (k = 0; k < 8; k++) begin
      dw.word = chain_v[k];
      dw.last = (k == 7);
      digest_q.push_back(dw);
    end
    restart_hash();
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  function automatic void queue_word(input sm3_pkg::word_t w, input logic [2:0] cnt,
                                     input logic fin);
    msg_item_t it;
    it.word = w;
    it.cnt  = cnt;
    it.fin  = fin;
    word_q.push_back(it);
    words_queued++;
  endfunction

  function automatic sm3_pkg::word_t pick_word();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // A message of n non-final words followed by its final word. The byte
  // count of non-final words is random, since the engine must ignore it.
  function automatic void queue_message(input int unsigned n, input logic [2:0] tail_cnt);
    int unsigned k;
    for (k = 0; k < n; k++) queue_word(pick_word(), 3'($urandom_range(0, 7)), 1'b0);
    queue_word(pick_word(), tail_cnt, 1'b1);
  endfunction

  function automatic int unsigned draw_pause(input logic calm);
    if (calm) return 0;
    return $urandom_range(0, 17);
  endfunction

  task automatic report_mismatch(input string what, input sm3_pkg::word_t got,
                                 input sm3_pkg::word_t exp_v);
    err_count++;
    $display("[%0t] %s: got %08h, expected %08h", $realtime, what, got, exp_v);
  endtask

  // ---------------------------------------------------------------------
  // Input driver. It runs at the falling edge, so the engine sees stable
  // inputs at every rising edge. in_tvalid gets exactly one nonblocking
  // assignment per edge, so back-to-back words never drop valid.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    nxt_valid = in_tvalid;
    if (in_tvalid && in_done) begin
      nxt_valid = 1'b0;
      // Occasionally switch between gapped and back-to-back sending.
      if ($urandom_range(0, 24) == 0) in_calm = ~in_calm;
      in_gap = draw_pause(in_calm);
    end
    if (rst_n && !nxt_valid) begin
      if (in_gap != 0) begin
        in_gap--;
      end else if (word_q.size() != 0) begin
        cur_item = word_q.pop_front();
        in_tdata <= cur_item.word;
        in_tuser <= cur_item.cnt;
        in_tlast <= cur_item.fin;
        nxt_valid = 1'b1;
      end
    end
    in_tvalid <= nxt_valid;
  end

  // ---------------------------------------------------------------------
  // Result side backpressure. After each transfer the receiver holds
  // out_tready low for a drawn number of cycles, then raises it and keeps
  // it high until the next transfer.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    nxt_ready = out_tready;
    if (!rst_n) begin
      nxt_ready = 1'b0;
    end else if (out_done) begin
      if ($urandom_range(0, 24) == 0) out_calm = ~out_calm;
      out_hold = draw_pause(out_calm);
      nxt_ready = (out_hold == 0);
    end else if (!nxt_ready) begin
      if (out_hold != 0) out_hold--;
      if (out_hold == 0) nxt_ready = 1'b1;
    end
    out_tready <= nxt_ready;
  end

  // ---------------------------------------------------------------------
  // Monitor. At each rising edge an accepted input word feeds the model and
  // an accepted result is checked against the oldest owed digest word.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    in_done  <= rst_n && in_tvalid && in_tready;
    out_done <= rst_n && out_tvalid && out_tready;
    if (rst_n && in_tvalid && in_tready) absorb_word(in_tdata, in_tuser, in_tlast);
    if (rst_n && out_tvalid && out_tready) begin
      if (digest_q.size() == 0) begin
        report_mismatch("digest word with none owed", out_tdata, '0);
      end else begin
        want = digest_q.pop_front();
        if (out_tdata !== want.word) report_mismatch("digest_word", out_tdata, want.word);
        if (out_tlast !== want.last)
          report_mismatch("digest_last", sm3_pkg::word_t'(out_tlast),
                          sm3_pkg::word_t'(want.last));
      end
    end
  end

  // Watchdog for a hung engine.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence: build every message, release reset and wait for the
  // engine to drain.
  // ---------------------------------------------------------------------
  initial begin
    int unsigned sel;
    int unsigned n;
    logic [2:0] tail;
    restart_hash();

    // Directed messages. The empty message carries garbage in the unused
    // bytes, which must be masked off before the pad byte goes in.
    queue_word(32'hFFFF_FFFF, 3'd0, 1'b1);
    // "abc" as a single short final word.
    queue_word(32'h6162_6300, 3'd3, 1'b1);
    // Final byte counts 1, 2, 4, 5 and 7, the last two saturated above four.
    queue_word(32'hFFFF_FFFF, 3'd1, 1'b1);
    queue_word(32'h1234_5678, 3'd2, 1'b1);
    queue_word(32'hFFFF_FFFF, 3'd4, 1'b1);
    queue_word(32'h0000_0000, 3'd5, 1'b1);
    queue_word(32'hFFFF_FFFF, 3'd7, 1'b1);
    // Non-final words count four bytes whatever their byte count says.
    queue_word(32'hA5A5_A5A5, 3'd0, 1'b0);
    queue_word(32'h5A5A_5A5A, 3'd7, 1'b0);
    queue_word(32'hFFFF_FFFF, 3'd6, 1'b1);
    // Final word at position fourteen: the length no longer fits and an
    // extra block of zeros plus length follows.
    for (int k = 0; k < 14; k++) queue_word(32'hFFFF_FFFF, 3'd4, 1'b0);
    queue_word(32'h0000_0000, 3'd2, 1'b1);

    // Random messages. Most are short, a good share ends near a block
    // boundary so the final word lands on positions 12 to 15, 0 or 1, and a few
    // span several blocks.
    while (words_queued < WORD_TARGET) begin
      sel = $urandom_range(0, 19);
      if (sel < 12) n = $urandom_range(0, 20);
      else if (sel < 19) n = 16 * $urandom_range(0, 2) + $urandom_range(12, 17);
      else n = $urandom_range(30, 48);
      tail = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(5, 7))
                                         : 3'($urandom_range(0, 4));
      queue_message(n, tail);
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait until every word has been taken, then until every digest word
    // has come back, then let the engine settle before the verdict.
    while (word_q.size() != 0 || in_tvalid) @(posedge clk);
    while (digest_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
